// ----- rtl/rfrc_pkg.sv -----
`default_nettype none

package rfrc_pkg;

  localparam int MAX_PEERS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;
  localparam int M_TDATA_W       = 48;

  typedef logic [7:0] byte_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_ADDR  = 3'd0,
    CFG_SYN_CODE    = 3'd1,
    CFG_PEER_COUNT  = 3'd2,
    CFG_PEER0       = 3'd3,
    CFG_PEER1       = 3'd4,
    CFG_PEER2       = 3'd5,
    CFG_PEER3       = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT         = 3'd1,
    ST_WRONG_RCPT    = 3'd2,
    ST_WRONG_SESSION = 3'd3,
    ST_BAD_CHECKSUM  = 3'd4
  } status_t;

  // one classified byte, front to back
  typedef struct packed {
    byte_t rx_byte;
    logic  is_payload;
    logic  last;
    logic  short_frame;
    logic  xor_ok;
    byte_t recipient;
    byte_t sender;
    byte_t packet;
    byte_t req_type;
    byte_t payload_len;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/rfrc_queue.sv -----
`default_nettype none

module rfrc_queue import rfrc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output item_t head_item,
  output logic  not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rfrc_front.sv -----
`default_nettype none

module rfrc_front import rfrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tlast,   // end_of_frame
  input  logic       q_not_full,
  output logic       q_push,
  output item_t      q_item
);

  localparam logic [2:0] POS_CHECKSUM  = 3'd0;
  localparam logic [2:0] POS_RECIPIENT = 3'd1;
  localparam logic [2:0] POS_SENDER    = 3'd2;
  localparam logic [2:0] POS_PACKET    = 3'd3;
  localparam logic [2:0] POS_TYPE      = 3'd4;
  localparam logic [2:0] POS_PAYLOAD   = 3'd5;

  logic [2:0] pos, pos_next;
  byte_t      xor_acc, xor_next;
  byte_t      chk, chk_next;
  byte_t      recip, recip_next;
  byte_t      sender, sender_next;
  byte_t      packet, packet_next;
  byte_t      req_type, req_type_next;
  byte_t      pay_cnt, pay_cnt_next;
  logic       is_payload;

  assign s_tready = q_not_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    chk_next      = chk;
    recip_next    = recip;
    sender_next   = sender;
    packet_next   = packet;
    req_type_next = req_type;
    pay_cnt_next  = pay_cnt;
    is_payload    = 1'b0;
    case (pos)
      POS_CHECKSUM:  chk_next      = s_tdata;
      POS_RECIPIENT: recip_next    = s_tdata;
      POS_SENDER:    sender_next   = s_tdata;
      POS_PACKET:    packet_next   = s_tdata;
      POS_TYPE:      req_type_next = s_tdata;
      default: begin
        is_payload = 1'b1;
        if (pay_cnt != 8'hff) begin
          pay_cnt_next = pay_cnt + 8'd1;
        end
      end
    endcase
    xor_next = (pos != POS_CHECKSUM) ? (xor_acc ^ s_tdata) : xor_acc;
    // hold at payload position for long frames
    pos_next = (pos < POS_PAYLOAD) ? pos + 3'd1 : pos;

    q_item.rx_byte     = s_tdata;
    q_item.is_payload  = is_payload;
    q_item.last        = s_tlast;
    q_item.short_frame = pos inside {[POS_CHECKSUM:POS_PACKET]};
    q_item.xor_ok      = (xor_next == chk_next);
    q_item.recipient   = recip_next;
    q_item.sender      = sender_next;
    q_item.packet      = packet_next;
    q_item.req_type    = req_type_next;
    q_item.payload_len = pay_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (q_push && s_tlast)) begin
      pos      <= POS_CHECKSUM;
      xor_acc  <= '0;
      chk      <= '0;
      recip    <= '0;
      sender   <= '0;
      packet   <= '0;
      req_type <= '0;
      pay_cnt  <= '0;
    end else if (q_push) begin
      pos      <= pos_next;
      xor_acc  <= xor_next;
      chk      <= chk_next;
      recip    <= recip_next;
      sender   <= sender_next;
      packet   <= packet_next;
      req_type <= req_type_next;
      pay_cnt  <= pay_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rfrc_back.sv -----
`default_nettype none

module rfrc_back import rfrc_pkg::*; #(
  parameter int MAX_PEERS = MAX_PEERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_not_empty,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  localparam byte_t NO_PARTNER = 8'hff;

  byte_t      local_addr;
  byte_t      syn_code;
  logic [2:0] peer_count;
  byte_t      peer [MAX_PEERS];
  byte_t      partner;

  logic       known_peer;
  logic       session_ok;
  status_t    verdict;

  byte_t      out_payload;
  logic       out_ok;
  status_t    out_status;
  byte_t      out_sender;
  byte_t      out_packet;
  byte_t      out_type;
  byte_t      out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= '0;
      syn_code   <= '0;
      peer_count <= '0;
      for (int i = 0; i < MAX_PEERS; i++) begin
        peer[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOCAL_ADDR: local_addr <= cfg_data;
        CFG_SYN_CODE:   syn_code   <= cfg_data;
        CFG_PEER_COUNT: peer_count <= cfg_data[2:0];
        default: begin
          for (int i = 0; i < MAX_PEERS; i++) begin
            if (cfg_index == CFG_IDX_W'(int'(CFG_PEER0) + i)) begin
              peer[i] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    known_peer = 1'b0;
    for (int i = 0; i < MAX_PEERS; i++) begin
      if ((3'(i) < peer_count) && (peer[i] == q_item.sender)) begin
        known_peer = 1'b1;
      end
    end
    session_ok = (q_item.sender == partner) ||
                 ((q_item.req_type == syn_code) && (partner == NO_PARTNER) && known_peer);
    if (q_item.short_frame) begin
      verdict = ST_SHORT;
    end else if (q_item.recipient != local_addr) begin
      verdict = ST_WRONG_RCPT;
    end else if (session_ok) begin
      verdict = q_item.xor_ok ? ST_OK : ST_BAD_CHECKSUM;
    end else begin
      verdict = ST_WRONG_SESSION;
    end
  end

  // advance when the output register is free or being drained
  assign q_pop = q_not_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      partner  <= NO_PARTNER;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // latch the partner even when the checksum then fails
      if (q_pop && q_item.last && !q_item.short_frame &&
          (q_item.recipient == local_addr) && session_ok) begin
        partner <= q_item.sender;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tuser     <= q_item.is_payload;
      m_tlast     <= q_item.last;
      out_payload <= q_item.is_payload ? q_item.rx_byte : '0;
      out_ok      <= q_item.last && (verdict == ST_OK);
      out_status  <= q_item.last ? verdict : ST_OK;
      out_sender  <= q_item.last ? q_item.sender : '0;
      out_packet  <= q_item.last ? q_item.packet : '0;
      out_type    <= q_item.last ? q_item.req_type : '0;
      out_len     <= q_item.last ? q_item.payload_len : '0;
    end
  end

  assign m_tdata = {4'd0, out_len, out_type, out_packet, out_sender,
                    3'(out_status), out_ok, out_payload};

endmodule

`default_nettype wire

// ----- rtl/radio_frame_receive_checker_unit.sv -----
// Channel  Direction  Signals                          Request
// s_*      in         tvalid tready tdata[7:0] tlast   one received byte
// m_*      out        tvalid tready tdata tlast tuser  one result per byte
// cfg_*    in         valid ready index[2:0] data[7:0] one register write
//
// One byte per cycle sustained while the queue has room; after its byte is accepted,
// the classified byte is written into the queue and then its verdict into the output register.
// The queue (QUEUE_DEPTH entries) decouples input and output stalls.
// Reset (rst, synchronous) clears frame state, registers and the session
// partner (no session); configuration writes are taken every cycle.
`default_nettype none

module radio_frame_receive_checker_unit import rfrc_pkg::*; #(
  parameter int MAX_PEERS   = MAX_PEERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  input  logic                  s_tlast,   // end_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] payload_byte, [8] frame_ok, [11:9] status, [19:12] sender,
  // [27:20] packet_number, [35:28] request_type, [43:36] payload_length
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tlast,   // frame_done
  output logic                  m_tuser,   // [0] payload_valid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_push;
  logic  q_pop;
  logic  q_not_full;
  logic  q_not_empty;
  item_t q_in;
  item_t q_head;

  assign cfg_ready = 1'b1;

  rfrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  rfrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .head_item (q_head),
    .not_empty (q_not_empty)
  );

  rfrc_back #(
    .MAX_PEERS (MAX_PEERS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_item      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/rfrc_checker.sv -----
`default_nettype none

module rfrc_checker import rfrc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast,
  input logic                 m_tuser
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // verdict fields only on the last byte of a frame
  a_verdict_only_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[43:8] == 36'd0)
    else $error("verdict fields set on a byte that is not last");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("payload byte set without payload flag");

  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[8] == (m_tdata[11:9] == ST_OK))
    else $error("frame_ok disagrees with status");

endmodule

bind radio_frame_receive_checker_unit rfrc_checker u_rfrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/radio_frame_receive_checker_unit_tb.sv -----
module radio_frame_receive_checker_unit_tb;
  import rfrc_pkg::*;

  localparam int MAX_PEERS = MAX_PEERS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam byte_t NO_PARTNER = 8'hff;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    byte_t data;
    logic  eof;
  } rx_req_t;

  typedef struct packed {
    byte_t   payload;
    logic    payload_valid;
    logic    done;
    logic    ok;
    status_t status;
    byte_t   sender;
    byte_t   packet;
    byte_t   req_type;
    byte_t   payload_len;
  } frame_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  radio_frame_receive_checker_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copy
  byte_t reg_local;
  byte_t reg_syn;
  logic [2:0] reg_peer_count;
  byte_t reg_peers [4];

  // per-frame and session state of the predictor
  logic [2:0] frm_pos;
  byte_t frm_xor, frm_csum, frm_rcpt, frm_sender, frm_packet, frm_type, frm_plen;
  byte_t sess_partner;

  rx_req_t rx_pending [$];
  frame_verdict_t verdicts [$];
  int queued_bytes = 0;
  int errs = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit peer_known(byte_t addr);
    int n;
    n = (reg_peer_count > MAX_PEERS) ? MAX_PEERS : int'(reg_peer_count);
    for (int i = 0; i < n; i++)
      if (reg_peers[i] == addr) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_frame();
    frm_pos = '0;
    frm_xor = '0;
    frm_csum = '0;
    frm_rcpt = '0;
    frm_sender = '0;
    frm_packet = '0;
    frm_type = '0;
    frm_plen = '0;
  endfunction

  // advance the frame state by one byte and queue the verdict it yields
  function automatic void predict_byte(byte_t b, logic eof);
    frame_verdict_t r;
    logic [2:0] pos;
    status_t st;
    r = '0;
    pos = frm_pos;
    case (pos)
      3'd0: frm_csum = b;
      3'd1: frm_rcpt = b;
      3'd2: frm_sender = b;
      3'd3: frm_packet = b;
      3'd4: frm_type = b;
      default: begin
        r.payload = b;
        r.payload_valid = 1'b1;
        if (frm_plen != 8'hff) frm_plen++;
      end
    endcase
    if (pos != 3'd0) frm_xor ^= b;
    if (pos < 3'd5) frm_pos = pos + 3'd1;
    if (eof) begin
      if (pos < 3'd4) begin
        st = ST_SHORT;
      end else if (frm_rcpt != reg_local) begin
        st = ST_WRONG_RCPT;
      end else if (frm_sender == sess_partner ||
                   (frm_type == reg_syn && sess_partner == NO_PARTNER &&
                    peer_known(frm_sender))) begin
        // partner latches even when the checksum then fails
        sess_partner = frm_sender;
        st = (frm_xor == frm_csum) ? ST_OK : ST_BAD_CHECKSUM;
      end else begin
        st = ST_WRONG_SESSION;
      end
      r.done = 1'b1;
      r.ok = (st == ST_OK);
      r.status = st;
      r.sender = frm_sender;
      r.packet = frm_packet;
      r.req_type = frm_type;
      r.payload_len = frm_plen;
      clear_frame();
    end
    verdicts.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    rx_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          req = rx_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= req.data;
          s_tlast <= req.eof;
          if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 4);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    frame_verdict_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdicts.size() == 0) begin
          $error("result with no request pending");
          errs++;
        end else begin
          e = verdicts.pop_front();
          check_field("payload_byte", int'(e.payload), int'(m_tdata[7:0]));
          check_field("payload_valid", int'(e.payload_valid), int'(m_tuser));
          check_field("frame_done", int'(e.done), int'(m_tlast));
          check_field("frame_ok", int'(e.ok), int'(m_tdata[8]));
          check_field("status", int'(e.status), int'(m_tdata[11:9]));
          check_field("sender", int'(e.sender), int'(m_tdata[19:12]));
          check_field("packet_number", int'(e.packet), int'(m_tdata[27:20]));
          check_field("request_type", int'(e.req_type), int'(m_tdata[35:28]));
          check_field("payload_length", int'(e.payload_len), int'(m_tdata[43:36]));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 4);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOCAL_ADDR: reg_local = val;
      CFG_SYN_CODE:   reg_syn = val;
      CFG_PEER_COUNT: reg_peer_count = val[2:0];
      CFG_PEER0:      reg_peers[0] = val;
      CFG_PEER1:      reg_peers[1] = val;
      CFG_PEER2:      reg_peers[2] = val;
      CFG_PEER3:      reg_peers[3] = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input byte_t local_addr, input byte_t syn,
                              input logic [2:0] count, input byte_t p0,
                              input byte_t p1, input byte_t p2, input byte_t p3);
    write_reg(CFG_LOCAL_ADDR, local_addr);
    write_reg(CFG_SYN_CODE, syn);
    write_reg(CFG_PEER_COUNT, {5'd0, count});
    write_reg(CFG_PEER0, p0);
    write_reg(CFG_PEER1, p1);
    write_reg(CFG_PEER2, p2);
    write_reg(CFG_PEER3, p3);
  endtask

  // hold until the block has drained every request
  task automatic wait_idle();
    do @(negedge clk); while (rx_pending.size() != 0 || s_tvalid || verdicts.size() != 0);
  endtask

  function automatic void push_byte(byte_t b, logic eof);
    rx_pending.push_back('{data: b, eof: eof});
    queued_bytes++;
  endfunction

  function automatic void queue_bytes(int n);
    for (int i = 0; i < n; i++) push_byte(byte_t'($urandom_range(0, 255)), i == n - 1);
  endfunction

  function automatic void queue_frame(byte_t rcpt, byte_t snd, byte_t pkt, byte_t typ,
                                      int plen, bit bad_sum);
    byte_t body [$];
    byte_t sum;
    body = '{rcpt, snd, pkt, typ};
    for (int i = 0; i < plen; i++) body.push_back(byte_t'($urandom_range(0, 255)));
    sum = '0;
    foreach (body[i]) sum ^= body[i];
    if (bad_sum) sum ^= byte_t'($urandom_range(1, 255));
    push_byte(sum, 1'b0);
    foreach (body[i]) push_byte(body[i], i == body.size() - 1);
  endfunction

  // mostly frames that reach the checksum check, with broken ones mixed in
  function automatic void random_frame(bit no_session);
    byte_t rc, sn, pk, ty;
    int plen, sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      queue_bytes($urandom_range(1, 4));
      return;
    end
    if (sel < 14) begin
      queue_bytes($urandom_range(5, 12));
      return;
    end
    rc = reg_local;
    pk = byte_t'($urandom_range(0, 255));
    ty = byte_t'($urandom_range(0, 255));
    plen = ($urandom_range(0, 199) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 12);
    if (!no_session) begin
      sn = sess_partner;
    end else if ($urandom_range(0, 1)) begin
      sn = NO_PARTNER;
    end else if ($urandom_range(0, 1)) begin
      sn = reg_peers[2'($urandom_range(0, 3))];
      ty = reg_syn;
    end else begin
      sn = byte_t'($urandom_range(0, 255));
    end
    if (sel < 22) rc ^= byte_t'($urandom_range(1, 255));
    else if (sel < 30) sn ^= byte_t'($urandom_range(1, 255));
    // keep the session closed until the dedicated SYN phase
    if (no_session && sn != NO_PARTNER && ty == reg_syn && peer_known(sn)) ty ^= 8'h01;
    queue_frame(rc, sn, pk, ty, plen, $urandom_range(0, 3) == 0);
  endfunction

  task automatic random_phase(input bit no_session, input int n_bytes);
    int stop_at;
    stop_at = queued_bytes + n_bytes;
    while (queued_bytes < stop_at) random_frame(no_session);
    wait_idle();
  endtask

  initial begin
    byte_t p3;
    reg_local = '0;
    reg_syn = '0;
    reg_peer_count = '0;
    foreach (reg_peers[i]) reg_peers[i] = '0;
    clear_frame();
    sess_partner = NO_PARTNER;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset values
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    queue_frame(8'h01, 8'h00, 8'h00, 8'h00, 0, 1'b0);
    queue_frame(8'h00, 8'h00, 8'h7f, 8'h00, 0, 1'b0);
    queue_frame(8'h00, NO_PARTNER, 8'hff, 8'hff, 2, 1'b0);
    wait_idle();

    // no session yet: SYN attempts from peers outside the counted list
    program_regs(8'hff, 8'h00, 3'd0, 8'h00, 8'hff, byte_t'($urandom), byte_t'($urandom));
    random_phase(1'b1, 120);
    program_regs(byte_t'($urandom), 8'hff, 3'd2, byte_t'($urandom), byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom));
    write_reg(CFG_UNUSED, byte_t'($urandom));
    random_phase(1'b1, 120);
    program_regs(8'h00, byte_t'($urandom), 3'd5, byte_t'($urandom), byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom));
    random_phase(1'b1, 120);

    // open the session from the last peer; bad checksum still latches it
    p3 = byte_t'($urandom_range(0, 254));
    program_regs(byte_t'($urandom), byte_t'($urandom), 3'd7, byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom), p3);
    queue_frame(reg_local, p3, byte_t'($urandom), reg_syn, 3, 1'b1);
    wait_idle();

    program_regs(8'h00, 8'hff, 3'd4, 8'hff, 8'h00, byte_t'($urandom), byte_t'($urandom));
    random_phase(1'b0, 160);
    program_regs(8'hff, 8'h00, 3'd1, byte_t'($urandom), byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom));
    queue_frame(reg_local, sess_partner, byte_t'($urandom), byte_t'($urandom), 260, 1'b0);
    random_phase(1'b0, 140);
    program_regs(byte_t'($urandom), byte_t'($urandom), 3'($urandom), byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
    random_phase(1'b0, 100);
    program_regs(byte_t'($urandom), byte_t'($urandom), 3'd7, byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
    random_phase(1'b0, 100);
    calm = 1'b1;
    program_regs(byte_t'($urandom), byte_t'($urandom), 3'($urandom), byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
    random_phase(1'b0, 180);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0 && verdicts.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
